// ===== hw/rtl/rrpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpc_pkg
// Shared types, register indexes, thresholds and palette for the radar return
// pixel classifier.
// ----------------------------------------------------------------------------
package rrpc_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA_MIN         = 2'd0,
		REG_BRIGHTNESS_MIN    = 2'd1,
		REG_GREY_SPREAD_LIMIT = 2'd2
	} reg_idx_t;

	localparam logic [7:0] ALPHA_MIN_RST         = 8'd24;
	localparam logic [7:0] BRIGHTNESS_MIN_RST    = 8'd88;
	localparam logic [7:0] GREY_SPREAD_LIMIT_RST = 8'd40;

	// grey class brightness steps
	localparam logic [7:0] GREY_BRIGHT_MIN = 8'd176;
	localparam logic [7:0] GREY_MID_MIN    = 8'd128;

	typedef enum logic [3:0] {
		CLS_GREY_BRIGHT = 4'd0,
		CLS_GREY_MID    = 4'd1,
		CLS_GREY_DIM    = 4'd2,
		CLS_RED         = 4'd3,
		CLS_ORANGE      = 4'd4,
		CLS_YELLOW      = 4'd5,
		CLS_GREEN       = 4'd6,
		CLS_PURPLE      = 4'd7,
		CLS_BLUE        = 4'd8
	} class_t;

	typedef struct packed {
		logic [7:0] alpha_min;
		logic [7:0] brightness_min;
		logic [7:0] grey_spread_limit;
	} cfg_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] return_class;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} result_t;

	function automatic logic [23:0] palette(input class_t cls);
		logic [23:0] rgb;
		unique case (cls)
			CLS_GREY_BRIGHT: rgb = {8'd255, 8'd226, 8'd118};
			CLS_GREY_MID:    rgb = {8'd114, 8'd216, 8'd255};
			CLS_GREY_DIM:    rgb = {8'd82,  8'd255, 8'd170};
			CLS_RED:         rgb = {8'd255, 8'd45,  8'd60};
			CLS_ORANGE:      rgb = {8'd255, 8'd132, 8'd38};
			CLS_YELLOW:      rgb = {8'd255, 8'd224, 8'd64};
			CLS_GREEN:       rgb = {8'd50,  8'd255, 8'd92};
			CLS_PURPLE:      rgb = {8'd186, 8'd112, 8'd255};
			CLS_BLUE:        rgb = {8'd64,  8'd204, 8'd255};
			default:         rgb = 24'd0;
		endcase
		return rgb;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rrpc_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpc_cfg_regs
// Threshold register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rrpc_cfg_regs import rrpc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_min         <= ALPHA_MIN_RST;
			cfg_q.brightness_min    <= BRIGHTNESS_MIN_RST;
			cfg_q.grey_spread_limit <= GREY_SPREAD_LIMIT_RST;
		end else if (cfg_we) begin
			// unused index is ignored
			unique case (cfg_index)
				REG_ALPHA_MIN:         cfg_q.alpha_min         <= cfg_data;
				REG_BRIGHTNESS_MIN:    cfg_q.brightness_min    <= cfg_data;
				REG_GREY_SPREAD_LIMIT: cfg_q.grey_spread_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rrpc_classify.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpc_classify
// Combinational classification of one ARGB pixel into a grey or hue class
// with its palette colour, or a reject with an all-zero result.
// ----------------------------------------------------------------------------
module rrpc_classify import rrpc_pkg::*; (
	input  wire logic [31:0] pixel,
	input  wire cfg_t        cfg,
	output result_t          res
);

	logic [7:0] a, r, g, b;
	logic [7:0] max_gb, max_rb, min_gb, mx, mn, spread;
	logic [8:0] r9, g9, b9;
	logic       reject;
	class_t     cls;
	logic       hit;
	logic [23:0] rgb;

	assign a = pixel[31:24];
	assign r = pixel[23:16];
	assign g = pixel[15:8];
	assign b = pixel[7:0];

	assign r9 = {1'b0, r};
	assign g9 = {1'b0, g};
	assign b9 = {1'b0, b};

	assign max_gb = (g > b) ? g : b;
	assign max_rb = (r > b) ? r : b;
	assign min_gb = (g < b) ? g : b;
	assign mx     = (r > max_gb) ? r : max_gb;
	assign mn     = (r < min_gb) ? r : min_gb;
	assign spread = mx - mn;

	assign reject = (a < cfg.alpha_min) || (mx < cfg.brightness_min);

	// differences compared as sums so nothing goes negative
	always_comb begin
		hit = 1'b1;
		cls = CLS_GREY_DIM;
		priority if (spread < cfg.grey_spread_limit) begin
			if (mx >= GREY_BRIGHT_MIN)   cls = CLS_GREY_BRIGHT;
			else if (mx >= GREY_MID_MIN) cls = CLS_GREY_MID;
			else                         cls = CLS_GREY_DIM;
		end else if (r >= 8'd200 && g <= 8'd110 && b <= 8'd120
				&& r9 >= {1'b0, max_gb} + 9'd45) begin
			cls = CLS_RED;
		end else if (r >= 8'd190 && g >= 8'd90 && g <= 8'd185 && b <= 8'd130
				&& r9 >= g9 + 9'd22) begin
			cls = CLS_ORANGE;
		end else if (r >= 8'd175 && g >= 8'd160 && b <= 8'd160
				&& r9 >= b9 + 9'd32 && g9 >= b9 + 9'd28) begin
			cls = CLS_YELLOW;
		end else if (g >= 8'd140 && r <= 8'd155 && b <= 8'd155
				&& g9 >= {1'b0, max_rb} + 9'd28) begin
			cls = CLS_GREEN;
		end else if (r >= 8'd140 && b >= 8'd140 && g <= 8'd135
				&& spread >= 8'd50) begin
			cls = CLS_PURPLE;
		end else if (b >= 8'd140 && g >= 8'd95 && r <= 8'd140
				&& b9 >= r9 + 9'd40 && g9 >= r9 + 9'd8) begin
			cls = CLS_BLUE;
		end else begin
			hit = 1'b0;
		end
	end

	assign rgb = palette(cls);

	always_comb begin
		if (reject || !hit) begin
			res = '0;
		end else begin
			res.accepted     = 1'b1;
			res.return_class = cls;
			res.red          = rgb[23:16];
			res.green        = rgb[15:8];
			res.blue         = rgb[7:0];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/radar_return_pixel_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radar_return_pixel_classifier
// Flags weather-radar return pixels in an ARGB stream and maps them to a
// fixed palette colour.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry pixel_argb; a transfer happens at a
// clock edge with in_valid high and in_stall low. Output channel: out_valid /
// out_stall carry accepted, return_class and out_red/out_green/out_blue, one
// result for every input pixel, in order.
// The pixel is registered, classified by compare and subtract logic, and the
// result registered. Throughput is one pixel per clock while the output is
// not stalled.
// A stalled output holds its result; the input register can still take one
// more pixel, after which in_stall rises until the output drains.
// The thresholds sit in three 8-bit registers written through cfg_we,
// cfg_index and cfg_data; the user must change them only while no pixel is
// in flight, which the block does not enforce. Reset (arst_n low) empties
// both stages and loads the default thresholds 24, 88 and 40.
// ----------------------------------------------------------------------------
module radar_return_pixel_classifier import rrpc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [31:0]           pixel_argb,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       accepted,
	output logic [3:0]                 return_class,
	output logic [7:0]                 out_red,
	output logic [7:0]                 out_green,
	output logic [7:0]                 out_blue,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t        cfg;
	result_t     res;
	result_t     res_s2;
	logic        valid_s1, valid_s2;
	logic [31:0] pixel_s1;
	logic        adv_s2, adv_s1;

	rrpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rrpc_classify u_classify (
		.pixel (pixel_s1),
		.cfg   (cfg),
		.res   (res)
	);

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) pixel_s1 <= pixel_argb;
		if (adv_s2 && valid_s1) res_s2   <= res;
	end

	assign out_valid    = valid_s2;
	assign accepted     = res_s2.accepted;
	assign return_class = res_s2.return_class;
	assign out_red      = res_s2.red;
	assign out_green    = res_s2.green;
	assign out_blue     = res_s2.blue;

`ifndef SYNTHESIS
	// stall only when both stages hold a pixel and the output is blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipeline");

	// a transfer in always lands in the input register
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("transferred pixel lost");

	// a pixel in the input register reaches the output register when it advances
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("classified pixel dropped");

	// rejected pixels carry an all-zero payload
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |->
		(return_class == CLS_GREY_BRIGHT && out_red == 8'd0
			&& out_green == 8'd0 && out_blue == 8'd0))
		else $error("rejected pixel with nonzero payload");

	// accepted pixels have a class in the defined set
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (return_class <= CLS_BLUE))
		else $error("class code out of range");
`endif

endmodule
`default_nettype wire
